FILE: rtl/core/spq_pkg.sv
`timescale 1ns / 1ps

package spq_pkg;

    typedef enum logic {
        REQ_ENQ = 1'b0,
        REQ_DEQ = 1'b1
    } req_t;

    typedef enum logic [1:0] {
        ERR_OK    = 2'd0,
        ERR_FULL  = 2'd1,
        ERR_EMPTY = 2'd2
    } err_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ENQ_RD,
        S_ENQ_CMP,
        S_DEQ_RD,
        S_DEQ_WR,
        S_DONE
    } state_t;

    // Status of the queue after one request, as handed to the output stage.
    typedef struct packed {
        logic empty;
        logic full;
        err_t err;
    } spq_status_t;

endpackage

FILE: rtl/core/sorted_priority_queue_unit.sv
`timescale 1ns / 1ps

// Channel  Handshake             Payload
// in       in_valid / in_stall   req_type, entry_data, entry_priority
// out      out_valid / out_stall head_data, head_priority, is_empty, is_full,
//                                error_code
//
// One request is handled at a time; in_stall is high from a transfer until
// its result has been loaded into the output register.
// An enqueue moves each entry that must go behind the new one back one slot,
// then writes the new entry; a dequeue moves each remaining entry forward one
// slot. The entry memory is accessed at most once a cycle, one read and one
// write per moved entry.
// A rejected request (full enqueue, empty dequeue) goes straight to the last
// step of the sequencer and leaves the entry memory alone.
// rst_n clears the entry count; the entry memory itself is not cleared.
// A result stalled in the output register holds the next result in the
// sequencer's last step; the work before that step goes on.

module sorted_priority_queue_unit #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int PRIO_WIDTH = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  req_type,
    input  logic [DATA_WIDTH-1:0] entry_data,
    input  logic [PRIO_WIDTH-1:0] entry_priority,
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [DATA_WIDTH-1:0] head_data,
    output logic [PRIO_WIDTH-1:0] head_priority,
    output logic                  is_empty,
    output logic                  is_full,
    output logic [1:0]            error_code
);

    import spq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int ENT_W = PRIO_WIDTH + DATA_WIDTH;

    logic                  seq_idle;
    logic                  seq_emit;
    logic                  start;
    logic                  out_free;
    logic [DATA_WIDTH-1:0] seq_head_data;
    logic [PRIO_WIDTH-1:0] seq_head_prio;
    spq_status_t           seq_status;

    logic                  mem_wr_en;
    logic [IDX_W-1:0]      mem_wr_addr;
    logic [ENT_W-1:0]      mem_wr_data;
    logic                  mem_rd_en;
    logic [IDX_W-1:0]      mem_rd_addr;
    logic [ENT_W-1:0]      mem_rd_data;

    logic                  out_valid_reg, out_valid_next;
    logic [DATA_WIDTH-1:0] head_data_reg;
    logic [PRIO_WIDTH-1:0] head_prio_reg;
    spq_status_t           status_reg;

    assign in_stall = !seq_idle;
    assign start    = in_valid && seq_idle;
    assign out_free = !out_valid_reg || !out_stall;

    spq_seq #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .PRIO_WIDTH (PRIO_WIDTH)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .req_type       (req_type),
        .entry_data     (entry_data),
        .entry_priority (entry_priority),
        .out_free       (out_free),
        .idle           (seq_idle),
        .emit           (seq_emit),
        .head_data      (seq_head_data),
        .head_priority  (seq_head_prio),
        .status         (seq_status),
        .mem_wr_en      (mem_wr_en),
        .mem_wr_addr    (mem_wr_addr),
        .mem_wr_data    (mem_wr_data),
        .mem_rd_en      (mem_rd_en),
        .mem_rd_addr    (mem_rd_addr),
        .mem_rd_data    (mem_rd_data)
    );

    spq_mem #(
        .DEPTH (DEPTH),
        .WIDTH (ENT_W)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_comb
    begin
        if (seq_emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (seq_emit)
        begin
            head_data_reg <= seq_head_data;
            head_prio_reg <= seq_head_prio;
            status_reg    <= seq_status;
        end
    end

    assign out_valid     = out_valid_reg;
    assign head_data     = head_data_reg;
    assign head_priority = head_prio_reg;
    assign is_empty      = status_reg.empty;
    assign is_full       = status_reg.full;
    assign error_code    = status_reg.err;

endmodule

FILE: rtl/core/spq_mem.sv
`timescale 1ns / 1ps

module spq_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 40
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/core/spq_seq.sv
`timescale 1ns / 1ps

module spq_seq #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int PRIO_WIDTH = 8
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic                             req_type,
    input  logic [DATA_WIDTH-1:0]            entry_data,
    input  logic [PRIO_WIDTH-1:0]            entry_priority,
    input  logic                             out_free,
    output logic                             idle,
    output logic                             emit,
    output logic [DATA_WIDTH-1:0]            head_data,
    output logic [PRIO_WIDTH-1:0]            head_priority,
    output spq_pkg::spq_status_t             status,
    output logic                             mem_wr_en,
    output logic [$clog2(DEPTH)-1:0]         mem_wr_addr,
    output logic [PRIO_WIDTH+DATA_WIDTH-1:0] mem_wr_data,
    output logic                             mem_rd_en,
    output logic [$clog2(DEPTH)-1:0]         mem_rd_addr,
    input  logic [PRIO_WIDTH+DATA_WIDTH-1:0] mem_rd_data
);

    import spq_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      idx_reg, idx_next;
    err_t                  err_reg, err_next;
    logic [DATA_WIDTH-1:0] data_reg, data_next;
    logic [PRIO_WIDTH-1:0] prio_reg, prio_next;
    logic [DATA_WIDTH-1:0] head_data_reg, head_data_next;
    logic [PRIO_WIDTH-1:0] head_prio_reg, head_prio_next;

    logic [CNT_W-1:0]      idx_dec;
    logic [CNT_W-1:0]      idx_inc;
    logic [DATA_WIDTH-1:0] rd_entry_data;
    logic [PRIO_WIDTH-1:0] rd_entry_prio;
    logic                  shift_up;

    assign idx_dec       = idx_reg - 1'b1;
    assign idx_inc       = idx_reg + 1'b1;
    assign rd_entry_data = mem_rd_data[DATA_WIDTH-1:0];
    assign rd_entry_prio = mem_rd_data[DATA_WIDTH +: PRIO_WIDTH];

    // The stored entries are always in non-decreasing priority order. The new
    // entry moves down past every larger key, and past equal keys too except
    // the head's, so that a tie with the head lands right behind it.
    assign shift_up = (rd_entry_prio > prio_reg) ||
                      ((idx_reg != CNT_W'(1)) && (rd_entry_prio == prio_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            idx_reg   <= '0;
            err_reg   <= ERR_OK;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            idx_reg   <= idx_next;
            err_reg   <= err_next;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg      <= data_next;
        prio_reg      <= prio_next;
        head_data_reg <= head_data_next;
        head_prio_reg <= head_prio_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        idx_next       = idx_reg;
        err_next       = err_reg;
        data_next      = data_reg;
        prio_next      = prio_reg;
        head_data_next = head_data_reg;
        head_prio_next = head_prio_reg;
        idle           = 1'b0;
        emit           = 1'b0;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = idx_reg[IDX_W-1:0];
        mem_wr_data    = {prio_reg, data_reg};
        mem_rd_en      = 1'b0;
        mem_rd_addr    = idx_reg[IDX_W-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                idle = 1'b1;
                if (start)
                begin
                    data_next = entry_data;
                    prio_next = entry_priority;
                    err_next  = ERR_OK;
                    if (req_type == REQ_ENQ)
                    begin
                        idx_next = count_reg;
                        if (count_reg == FULL_CNT)
                        begin
                            err_next   = ERR_FULL;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_ENQ_RD;
                        end
                    end
                    else
                    begin
                        idx_next = CNT_W'(1);
                        if (count_reg == '0)
                        begin
                            err_next   = ERR_EMPTY;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            state_next = S_DEQ_RD;
                        end
                    end
                end
            end

            S_ENQ_RD:
            begin
                if (idx_reg == '0)
                begin
                    // The new entry becomes the head.
                    mem_wr_en      = 1'b1;
                    head_data_next = data_reg;
                    head_prio_next = prio_reg;
                    count_next     = count_reg + 1'b1;
                    state_next     = S_DONE;
                end
                else
                begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = idx_dec[IDX_W-1:0];
                    state_next  = S_ENQ_CMP;
                end
            end

            S_ENQ_CMP:
            begin
                mem_wr_en = 1'b1;
                if (shift_up)
                begin
                    mem_wr_data = mem_rd_data;
                    idx_next    = idx_dec;
                    state_next  = S_ENQ_RD;
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    state_next = S_DONE;
                end
            end

            S_DEQ_RD:
            begin
                if (idx_reg == count_reg)
                begin
                    count_next = count_reg - 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    mem_rd_en  = 1'b1;
                    state_next = S_DEQ_WR;
                end
            end

            S_DEQ_WR:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = idx_dec[IDX_W-1:0];
                mem_wr_data = mem_rd_data;
                if (idx_reg == CNT_W'(1))
                begin
                    head_data_next = rd_entry_data;
                    head_prio_next = rd_entry_prio;
                end
                idx_next   = idx_inc;
                state_next = S_DEQ_RD;
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign status.empty  = (count_reg == '0);
    assign status.full   = (count_reg == FULL_CNT);
    assign status.err    = err_reg;
    assign head_data     = status.empty ? '0 : head_data_reg;
    assign head_priority = status.empty ? '0 : head_prio_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_CNT)
        else $error("entry count exceeds queue depth");

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == S_IDLE))
        else $error("request started while sequencer busy");

    a_cmp_after_rd: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ENQ_CMP) |-> ($past(state_reg) == S_ENQ_RD))
        else $error("compare step without preceding read");

    a_full_err: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (err_reg == ERR_FULL)) |-> status.full)
        else $error("dropped enqueue reported on a queue that is not full");

    a_empty_err: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && (err_reg == ERR_EMPTY)) |-> status.empty)
        else $error("empty dequeue reported on a queue that holds entries");
`endif

endmodule

FILE: dv/sorted_priority_queue_unit_test.sv
`timescale 1ns / 1ps

module sorted_priority_queue_unit_test;

    import spq_pkg::*;

    localparam int DEPTH        = 16;
    localparam int DATA_W       = 32;
    localparam int PRIO_W       = 8;
    localparam int RANDOM_ITEMS = 1700;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 60;
    localparam int CYCLE_LIMIT  = 600000;

    logic              clk            = 1'b0;
    logic              rst_n          = 1'b0;
    logic              in_valid       = 1'b0;
    logic              in_stall;
    logic              req_type       = 1'b0;
    logic [DATA_W-1:0] entry_data     = '0;
    logic [PRIO_W-1:0] entry_priority = '0;
    logic              out_valid;
    logic              out_stall      = 1'b0;
    logic [DATA_W-1:0] head_data;
    logic [PRIO_W-1:0] head_priority;
    logic              is_empty;
    logic              is_full;
    logic [1:0]        error_code;

    // Handshake shaping for the sender and the receiver.
    bit          sender_steady   = 1'b0;
    logic        receiver_steady = 1'b0;
    logic        hold_request    = 1'b0;
    logic        hold_taken      = 1'b0;
    int unsigned hold_left       = 0;
    int unsigned cycle_count     = 0;

    typedef struct {
        logic [DATA_W-1:0] data;
        logic [PRIO_W-1:0] prio;
        logic              empty;
        logic              full;
        err_t              err;
    } head_report_t;

    class priority_queue_scoreboard;
        logic [DATA_W-1:0] slot_data [DEPTH];
        logic [PRIO_W-1:0] slot_prio [DEPTH];
        int unsigned       fill;
        head_report_t      expected_heads [$];
        int unsigned       mismatches;

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        // Applies one accepted request to the shadow queue and records the
        // head report that the block must return for it.
        function void note_request(req_t kind, logic [DATA_W-1:0] d,
                                   logic [PRIO_W-1:0] p);
            head_report_t rep;
            int unsigned  pos;
            int unsigned  i;
            rep.err = ERR_OK;
            if (kind == REQ_ENQ) begin
                if (fill >= DEPTH) begin
                    rep.err = ERR_FULL;
                end
                else begin
                    pos = 0;
                    // Ties with the head and later entries land right behind
                    // the head and ahead of equal keys.
                    if (fill != 0 && !(p < slot_prio[0])) begin
                        pos = 1;
                        while (pos < fill && slot_prio[pos] < p)
                            pos++;
                    end
                    for (i = fill; i > pos; i--) begin
                        slot_data[i] = slot_data[i-1];
                        slot_prio[i] = slot_prio[i-1];
                    end
                    slot_data[pos] = d;
                    slot_prio[pos] = p;
                    fill++;
                end
            end
            else begin
                if (fill == 0) begin
                    rep.err = ERR_EMPTY;
                end
                else begin
                    for (i = 1; i < fill; i++) begin
                        slot_data[i-1] = slot_data[i];
                        slot_prio[i-1] = slot_prio[i];
                    end
                    fill--;
                end
            end
            rep.data  = (fill == 0) ? '0 : slot_data[0];
            rep.prio  = (fill == 0) ? '0 : slot_prio[0];
            rep.empty = (fill == 0);
            rep.full  = (fill >= DEPTH);
            expected_heads.push_back(rep);
        endfunction

        function void check_result(logic [DATA_W-1:0] d, logic [PRIO_W-1:0] p,
                                   logic e, logic f, logic [1:0] code);
            head_report_t rep;
            if (expected_heads.size() == 0) begin
                $error("result transfer with no request outstanding");
                mismatches++;
                return;
            end
            rep = expected_heads.pop_front();
            if (d !== rep.data) begin
                $error("head_data: expected %h, actual %h", rep.data, d);
                mismatches++;
            end
            if (p !== rep.prio) begin
                $error("head_priority: expected %h, actual %h", rep.prio, p);
                mismatches++;
            end
            if (e !== rep.empty) begin
                $error("is_empty: expected %b, actual %b", rep.empty, e);
                mismatches++;
            end
            if (f !== rep.full) begin
                $error("is_full: expected %b, actual %b", rep.full, f);
                mismatches++;
            end
            if (code !== rep.err) begin
                $error("error_code: expected %0d, actual %0d", rep.err, code);
                mismatches++;
            end
        endfunction

        function int unsigned pending();
            return expected_heads.size();
        endfunction
    endclass

    priority_queue_scoreboard queue_model = new();

    sorted_priority_queue_unit #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_W),
        .PRIO_WIDTH (PRIO_W)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .req_type       (req_type),
        .entry_data     (entry_data),
        .entry_priority (entry_priority),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .head_data      (head_data),
        .head_priority  (head_priority),
        .is_empty       (is_empty),
        .is_full        (is_full),
        .error_code     (error_code)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("sorted_priority_queue_unit_test: done, errors");
            $finish;
        end
    end

    // Result side: check each transfer, then pick the next stall value.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            queue_model.check_result(head_data, head_priority, is_empty, is_full,
                                     error_code);
        if (hold_left != 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_request && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            out_stall  <= 1'b1;
        end
        else begin
            out_stall <= !receiver_steady && ($urandom_range(99) < 27);
        end
    end

    // Called just after a rising edge; returns just after the accepting edge.
    task automatic send_request(req_t kind, logic [DATA_W-1:0] d,
                                logic [PRIO_W-1:0] p);
        while (!sender_steady && $urandom_range(99) < 27) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        req_type       <= kind;
        entry_data     <= d;
        entry_priority <= p;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        queue_model.note_request(kind, d, p);
    endtask

    task automatic send_random(int unsigned enq_percent);
        req_t              kind;
        logic [PRIO_W-1:0] p;
        int unsigned       sel;
        kind = ($urandom_range(99) < enq_percent) ? REQ_ENQ : REQ_DEQ;
        sel  = $urandom_range(99);
        // Mostly a narrow key range so that ties are common.
        if (sel < 45)
            p = PRIO_W'($urandom_range(7));
        else if (sel < 55)
            p = '0;
        else if (sel < 62)
            p = '1;
        else
            p = PRIO_W'($urandom_range(255));
        send_request(kind, $urandom, p);
    endtask

    task automatic wait_for_quiet();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (queue_model.pending() != 0);
    endtask

    initial
    begin
        int unsigned sent;
        int unsigned run_length;
        int unsigned enq_percent;
        int unsigned k;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed opening: empty dequeue, key extremes, ties, full queue.
        send_request(REQ_DEQ, 32'hFFFF_FFFF, 8'hFF);
        send_request(REQ_ENQ, 32'hFFFF_FFFF, 8'hFF);
        send_request(REQ_ENQ, 32'h0000_0000, 8'h00);
        send_request(REQ_ENQ, 32'h0000_0001, 8'h00);
        send_request(REQ_ENQ, 32'hA5A5_A5A5, 8'hFF);
        send_request(REQ_ENQ, 32'h5A5A_5A5A, 8'h80);
        send_request(REQ_ENQ, 32'h1234_5678, 8'h01);
        for (k = 0; k < 10; k++)
            send_request(REQ_ENQ, $urandom, PRIO_W'($urandom_range(255)));
        send_request(REQ_ENQ, 32'hFFFF_FFFF, 8'h00);
        send_request(REQ_ENQ, 32'h0000_0000, 8'hFF);
        for (k = 0; k < 4; k++)
            send_request(REQ_DEQ, $urandom, PRIO_W'($urandom_range(255)));
        wait_for_quiet();

        // Random part: runs that lean toward filling or draining the queue, or
        // neither, so that both the full and the empty boundaries come up often.
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            run_length = $urandom_range(60, 15);
            case ($urandom_range(2))
                0:       enq_percent = 75;
                1:       enq_percent = 25;
                default: enq_percent = 50;
            endcase
            for (k = 0; k < run_length; k++) begin
                send_random(enq_percent);
                sent++;
                if (sent == 400) begin
                    wait_for_quiet();
                end
                else if (sent == 700) begin
                    sender_steady    = 1'b1;
                    receiver_steady <= 1'b1;
                end
                else if (sent == 950) begin
                    sender_steady    = 1'b0;
                    receiver_steady <= 1'b0;
                end
                else if (sent == 1200) begin
                    // The receiver stalls for a long stretch while transfers
                    // keep being offered, so the input side backs up.
                    sender_steady  = 1'b1;
                    hold_request  <= 1'b1;
                end
                else if (sent == 1240) begin
                    sender_steady  = 1'b0;
                    hold_request  <= 1'b0;
                end
            end
        end

        in_valid <= 1'b0;
        while (queue_model.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (queue_model.mismatches == 0)
            $display("sorted_priority_queue_unit_test: done, clean");
        else
            $display("sorted_priority_queue_unit_test: done, errors");
        $finish;
    end

endmodule
